[src/lpfd_pkg.sv]
`timescale 1ns / 1ps

package lpfd_pkg;

   // header lengths in bytes
   localparam int unsigned SHORT_HDR_BYTES = 4;
   localparam int unsigned LONG_HDR_BYTES  = 8;

   localparam int unsigned SEEN_W    = 3;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned BYTES_W   = 64;

   // last header byte index, as held in the seen counter
   localparam logic [SEEN_W-1:0] SHORT_HDR_LAST = SEEN_W'(SHORT_HDR_BYTES - 1);
   localparam logic [SEEN_W-1:0] LONG_HDR_LAST  = SEEN_W'(LONG_HDR_BYTES - 1);

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_NAMELEN,
      PH_NAME,
      PH_DATALEN,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      KIND_STATUS,
      KIND_NAME,
      KIND_DATA,
      KIND_EMPTY_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT_COUNT,
      ST_SHORT_NAMELEN,
      ST_SHORT_NAME,
      ST_SHORT_DATALEN,
      ST_SHORT_DATA
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      kind_type           out_kind;
      logic [COUNT_W-1:0] file_number;
      logic               field_end;
      logic               done_res;
      status_type         status;
   } rsp_type;

endpackage

[src/lpfd_parser.sv]
`timescale 1ns / 1ps

module lpfd_parser
   import lpfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req,
   output logic    res_valid,
   output rsp_type res
);

   phase_type          phase_ff, phase_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [COUNT_W-1:0] files_left_ff, files_left_in;
   logic [BYTES_W-1:0] bytes_left_ff, bytes_left_in;
   logic [COUNT_W-1:0] cur_file_ff, cur_file_in;

   logic               in_header;
   logic               hdr_done;
   logic [BYTES_W-1:0] acc;
   logic [BYTES_W-1:0] dec;
   logic               field_last;
   logic [COUNT_W-1:0] files_dec;
   logic               empty_data;

   // shared decode
   assign in_header  = (phase_ff == PH_COUNT) || (phase_ff == PH_NAMELEN) ||
                       (phase_ff == PH_DATALEN);
   assign hdr_done   = (phase_ff == PH_DATALEN) ? (seen_ff == LONG_HDR_LAST)
                                                : (seen_ff == SHORT_HDR_LAST);
   assign acc        = (seen_ff == '0) ? {{(BYTES_W-8){1'b0}}, req.in_byte}
                                       : {bytes_left_ff[BYTES_W-9:0], req.in_byte};
   assign dec        = bytes_left_ff - BYTES_W'(1);
   assign field_last = (bytes_left_ff == BYTES_W'(1));
   assign files_dec  = files_left_ff - COUNT_W'(1);
   assign empty_data = (phase_ff == PH_DATALEN) && hdr_done && (acc == '0);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      seen_in       = seen_ff;
      files_left_in = files_left_ff;
      bytes_left_in = bytes_left_ff;
      cur_file_in   = cur_file_ff;
      case (phase_ff)
         PH_COUNT, PH_NAMELEN, PH_DATALEN: begin
            bytes_left_in = acc;
            seen_in       = seen_ff + SEEN_W'(1);
            if (hdr_done) begin
               seen_in = '0;
               if (phase_ff == PH_COUNT) begin
                  files_left_in = acc[COUNT_W-1:0];
                  bytes_left_in = '0;
                  phase_in      = (acc[COUNT_W-1:0] != '0) ? PH_NAMELEN : PH_TRAIL;
               end else if (phase_ff == PH_NAMELEN) begin
                  bytes_left_in = {{(BYTES_W-COUNT_W){1'b0}}, acc[COUNT_W-1:0]};
                  phase_in      = (acc[COUNT_W-1:0] != '0) ? PH_NAME : PH_DATALEN;
               end else if (acc != '0) begin
                  phase_in = PH_DATA;
               end else begin
                  cur_file_in   = cur_file_ff + COUNT_W'(1);
                  files_left_in = files_dec;
                  bytes_left_in = '0;
                  phase_in      = (files_dec != '0) ? PH_NAMELEN : PH_TRAIL;
               end
            end
         end
         PH_NAME: begin
            bytes_left_in = dec;
            if (field_last) phase_in = PH_DATALEN;
         end
         PH_DATA: begin
            bytes_left_in = dec;
            if (field_last) begin
               cur_file_in   = cur_file_ff + COUNT_W'(1);
               files_left_in = files_dec;
               bytes_left_in = '0;
               phase_in      = (files_dec != '0) ? PH_NAMELEN : PH_TRAIL;
            end
         end
         default: begin
            // trailing bytes ignored
         end
      endcase
   end

   // result
   always_comb begin
      res             = '0;
      res.out_kind    = KIND_STATUS;
      res.status      = ST_OK;
      res.file_number = cur_file_ff;
      res.done_res    = req.in_last;
      res_valid       = req.in_last;
      case (phase_ff)
         PH_NAME: begin
            res_valid     = 1'b1;
            res.out_kind  = KIND_NAME;
            res.out_byte  = req.in_byte;
            res.field_end = field_last;
         end
         PH_DATA: begin
            res_valid     = 1'b1;
            res.out_kind  = KIND_DATA;
            res.out_byte  = req.in_byte;
            res.field_end = field_last;
         end
         default: begin
            if (in_header && empty_data) begin
               res_valid     = 1'b1;
               res.out_kind  = KIND_EMPTY_END;
               res.field_end = 1'b1;
            end
         end
      endcase
      // status reflects where parsing stands after this byte
      if (req.in_last) begin
         case (phase_in)
            PH_COUNT:   res.status = ST_SHORT_COUNT;
            PH_NAMELEN: res.status = ST_SHORT_NAMELEN;
            PH_NAME:    res.status = ST_SHORT_NAME;
            PH_DATALEN: res.status = ST_SHORT_DATALEN;
            PH_DATA:    res.status = ST_SHORT_DATA;
            default:    res.status = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && req.in_last)) begin
         phase_ff      <= PH_COUNT;
         seen_ff       <= '0;
         files_left_ff <= '0;
         bytes_left_ff <= '0;
         cur_file_ff   <= '0;
      end else if (take) begin
         phase_ff      <= phase_in;
         seen_ff       <= seen_in;
         files_left_ff <= files_left_in;
         bytes_left_ff <= bytes_left_in;
         cur_file_ff   <= cur_file_in;
      end
   end

endmodule

[src/length_prefixed_file_deframer_top.sv]
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// req_      in   req_valid / req_stall     req_data  (in_byte, in_last)
// rsp_      out  rsp_valid / rsp_stall     rsp_data  (byte, kind, file, end, done, status)
//
// one byte is taken per cycle while req_stall is low; its result (if any) is registered for rsp_
// the parse state is a handful of counters updated in the cycle a byte transfers
// a two-entry output stage (result register plus skid) still takes a byte in a
// cycle rsp_stall is high; req_stall rises only when both are full and stays
// high up to and including the cycle in which the skid entry moves on
// reset is synchronous and clears the parse state and both output entries
// a last byte also returns the parse state to its reset values

module length_prefixed_file_deframer_top
   import lpfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    take;
   logic    res_valid;
   rsp_type res;

   // result register and skid entry
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    out_free;

   // stall only when the skid entry is occupied
   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !req_stall;

   lpfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register may load when empty or its transfer happens now
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid first; no new byte is taken this cycle
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= take && res_valid;
         end
      end else if (take && res_valid) begin
         // result register held, park the new result
         skid_valid_ff <= 1'b1;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (take && res_valid) begin
            rsp_data_ff <= res;
         end
      end else if (take && res_valid) begin
         skid_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/lpfd_checker.sv]
`timescale 1ns / 1ps

module lpfd_checker
   import lpfd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // nothing left in the output stage after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output stage not empty after reset");

   // an error status only comes with the closing result
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.done_res)
      else $error("error status without done");

   // a status-only result is the done result and carries no byte
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_STATUS) |->
         (rsp_data.done_res && !rsp_data.field_end && rsp_data.out_byte == 8'd0))
      else $error("malformed status-only result");

   // an empty-data marker closes its field and carries no byte
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_EMPTY_END) |->
         (rsp_data.field_end && rsp_data.out_byte == 8'd0))
      else $error("malformed empty-data marker");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind length_prefixed_file_deframer_top lpfd_checker u_lpfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

// deframer testbench: directed table first, then random buffers; results are checked in
// transfer order against typed rows' hand-written results or an in-bench parser model

module tb_top;
   import lpfd_pkg::*;

   localparam int RANDOM_ITEMS   = 1500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   localparam rsp_type NO_RESULT = '0;

   // one row of the directed table; typed rows carry a hand-written result
   typedef struct {
      logic [7:0] data_byte;
      logic       is_last;
      bit         typed;
      rsp_type    want;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // idle and stall odds in percent, changed between phases
   int feed_idle_pct  = 0;
   int drain_stall_pct = 0;

   // expectations in transfer order
   rsp_type pending_results [$];
   bit      failed = 1'b0;

   // item currently on the input channel: hand-written result or model
   bit      row_typed = 1'b0;
   rsp_type row_want  = '0;

   // bytes of the random buffer being built
   logic [7:0] frame_q [$];

   // parser model state
   phase_type    parse_phase = PH_COUNT;
   logic [2:0]   hdr_count   = '0;
   logic [31:0]  files_to_go = '0;
   logic [63:0]  remaining   = '0;
   logic [31:0]  file_idx    = '0;

   // short count, zero file count, then one file with empty name and data, then trailing bytes
   directed_row_type directed_rows [24] = '{
      // lone last byte: buffer ends inside the count header
      '{8'h5a, 1'b1, 1'b1, '{8'h00, KIND_STATUS, 32'd0, 1'b0, 1'b1, ST_SHORT_COUNT}},
      // zero file count, then a trailing byte that closes the buffer
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hff, 1'b1, 1'b1, '{8'h00, KIND_STATUS, 32'd0, 1'b0, 1'b1, ST_OK}},
      // one file
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      // empty name
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      // empty data: the last length byte gives the boundary marker
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, '{8'h00, KIND_EMPTY_END, 32'd0, 1'b1, 1'b0, ST_OK}},
      // trailing bytes are ignored, the last one reports the file count
      '{8'hff, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b1, 1'b1, '{8'h00, KIND_STATUS, 32'd1, 1'b0, 1'b1, ST_OK}}
   };

   length_prefixed_file_deframer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < drain_stall_pct);
   end

   // ------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------

   function automatic void clear_parse();
      parse_phase = PH_COUNT;
      hdr_count   = '0;
      files_to_go = '0;
      remaining   = '0;
      file_idx    = '0;
   endfunction

   // one file fully taken: next file's name length, or trailing bytes
   function automatic void close_file();
      file_idx    = file_idx + 32'd1;
      files_to_go = files_to_go - 32'd1;
      remaining   = '0;
      parse_phase = (files_to_go != 0) ? PH_NAMELEN : PH_TRAIL;
   endfunction

   // takes one byte, returns 1 with the result when the byte produces one
   function automatic bit parse_byte(input logic [7:0] data_byte, input logic is_last,
                                     output rsp_type r);
      bit         emit;
      logic [2:0] hdr_last;
      emit = 1'b0;
      r = NO_RESULT;
      r.file_number = file_idx;
      case (parse_phase)
         PH_COUNT, PH_NAMELEN, PH_DATALEN: begin
            // headers accumulate big-endian, data length is the long one
            remaining = (hdr_count == 0) ? {56'd0, data_byte} : {remaining[55:0], data_byte};
            hdr_last  = (parse_phase == PH_DATALEN) ? LONG_HDR_LAST : SHORT_HDR_LAST;
            if (hdr_count == hdr_last) begin
               hdr_count = '0;
               if (parse_phase == PH_COUNT) begin
                  files_to_go = remaining[31:0];
                  remaining   = '0;
                  parse_phase = (files_to_go != 0) ? PH_NAMELEN : PH_TRAIL;
               end else if (parse_phase == PH_NAMELEN) begin
                  remaining   = {32'd0, remaining[31:0]};
                  parse_phase = (remaining != 0) ? PH_NAME : PH_DATALEN;
               end else if (remaining != 0) begin
                  parse_phase = PH_DATA;
               end else begin
                  // empty data closes the file with a marker
                  emit = 1'b1;
                  r.out_kind  = KIND_EMPTY_END;
                  r.field_end = 1'b1;
                  close_file();
               end
            end else begin
               hdr_count = hdr_count + 3'd1;
            end
         end
         PH_NAME, PH_DATA: begin
            emit = 1'b1;
            r.out_kind = (parse_phase == PH_NAME) ? KIND_NAME : KIND_DATA;
            r.out_byte = data_byte;
            remaining  = remaining - 64'd1;
            if (remaining == 0) begin
               r.field_end = 1'b1;
               if (parse_phase == PH_NAME) begin
                  parse_phase = PH_DATALEN;
               end else begin
                  close_file();
               end
            end
         end
         default: ;  // trailing bytes are dropped
      endcase
      // the buffer's last byte always reports, riding on any payload result
      if (is_last) begin
         emit = 1'b1;
         r.done_res = 1'b1;
         case (parse_phase)
            PH_COUNT:   r.status = ST_SHORT_COUNT;
            PH_NAMELEN: r.status = ST_SHORT_NAMELEN;
            PH_NAME:    r.status = ST_SHORT_NAME;
            PH_DATALEN: r.status = ST_SHORT_DATALEN;
            PH_DATA:    r.status = ST_SHORT_DATA;
            default:    r.status = ST_OK;
         endcase
         clear_parse();
      end
      return emit;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // result transfers are compared before the same edge's input transfer is
   // modeled; a byte's result only reaches rsp_ through a register anyway
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type model_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: kind %0d byte %0h file %0d done %0b",
                      rsp_data.out_kind, rsp_data.out_byte, rsp_data.file_number,
                      rsp_data.done_res);
               failed = 1'b1;
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_data.out_byte));
               check_field("out_kind", 64'(want.out_kind), 64'(rsp_data.out_kind));
               check_field("file_number", 64'(want.file_number),
                           64'(rsp_data.file_number));
               check_field("field_end", 64'(want.field_end), 64'(rsp_data.field_end));
               check_field("done_res", 64'(want.done_res), 64'(rsp_data.done_res));
               check_field("status", 64'(want.status), 64'(rsp_data.status));
            end
         end
         if (req_valid && !req_stall) begin
            // model runs on every byte so its state tracks typed rows too
            if (parse_byte(req_data.in_byte, req_data.in_last, model_rsp) && !row_typed) begin
               pending_results = {pending_results, model_rsp};
            end
            if (row_typed) begin
               pending_results = {pending_results, row_want};
            end
         end
      end
   end

   // ends the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end while (quiet < WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // enters and leaves at a falling edge; valid is only dropped when a gap is
   // drawn, so back-to-back bytes keep it high with a single assignment
   task automatic send_byte(input logic [7:0] data_byte, input logic is_last,
                            input bit typed, input rsp_type want);
      int gaps;
      gaps = 0;
      while ($urandom_range(0, 99) < feed_idle_pct) gaps++;
      if (gaps != 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {data_byte, is_last};
      row_typed = typed;
      row_want  = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // big-endian header of n bytes
   task automatic put_be(input logic [63:0] value, input int n);
      for (int i = n - 1; i >= 0; i--) frame_q = {frame_q, value[i*8 +: 8]};
   endtask

   initial begin : stimulus
      int random_sent;
      int idle_phase;
      int roll;
      int oversize;
      int nfiles;
      int len;
      int cut;
      bit stop;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data_byte, directed_rows[i].is_last,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      random_sent = 0;
      idle_phase  = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // new idle phase: hold off until every expected result is back
         if (random_sent * 4 / RANDOM_ITEMS != idle_phase) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (pending_results.size() != 0);
            idle_phase = random_sent * 4 / RANDOM_ITEMS;
            case (idle_phase)
               1: begin feed_idle_pct = 46; drain_stall_pct = 0;  end
               2: begin feed_idle_pct = 0;  drain_stall_pct = 46; end
               default: begin feed_idle_pct = 12; drain_stall_pct = 12; end
            endcase
         end

         frame_q.delete();
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            // noise buffer, parses to whatever it parses to
            repeat ($urandom_range(1, 12)) frame_q = {frame_q, 8'($urandom)};
         end else begin
            // one in five buffers has an oversized count, name or data length
            // and is cut short somewhere after it
            oversize = (roll < 30) ? $urandom_range(1, 3) : 0;
            nfiles   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            put_be((oversize == 1) ? {32'd0, $urandom} : 64'(nfiles), 4);
            stop = 1'b0;
            for (int f = 0; f < nfiles && !stop; f++) begin
               if (oversize == 2 && f == nfiles - 1) begin
                  put_be({32'd0, $urandom}, 4);
                  stop = 1'b1;
               end else begin
                  len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
                  put_be(64'(len), 4);
                  repeat (len) frame_q = {frame_q, 8'($urandom)};
                  if (oversize == 3 && f == nfiles - 1) begin
                     put_be({$urandom, $urandom}, 8);
                     stop = 1'b1;
                  end else begin
                     len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                     put_be(64'(len), 8);
                     repeat (len) frame_q = {frame_q, 8'($urandom)};
                  end
               end
            end
            if (stop) begin
               repeat ($urandom_range(0, 10)) frame_q = {frame_q, 8'($urandom)};
            end else if (oversize == 0) begin
               // trailing junk, and now and then a truncated buffer
               repeat ($urandom_range(0, 3)) frame_q = {frame_q, 8'($urandom)};
               if ($urandom_range(0, 3) == 0) begin
                  cut = $urandom_range(1, frame_q.size());
                  while (frame_q.size() > cut) void'(frame_q.pop_back());
               end
            end
         end

         foreach (frame_q[i]) begin
            send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_RESULT);
         end
         random_sent += frame_q.size();
      end

      // let the last results drain out
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (!failed) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
